### sv/huffman_code_builder_assert.svh
`ifndef HUFFMAN_CODE_BUILDER_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_ASSERT_SVH

// check on every clock edge outside reset
`define HCB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define HCB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/hcb_pkg.sv
package hcb_pkg;

	localparam int SYM_W    = 8;
	localparam int FREQ_W   = 16;
	localparam int WEIGHT_W = 22;
	localparam int CODE_W   = 31;
	localparam int LEN_W    = 5;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_HINIT,
		OP_RD_HI,
		OP_LD_X,
		OP_SD_RL,
		OP_SD_RR,
		OP_SD_CMP,
		OP_HDEC,
		OP_RD_TOP,
		OP_TM1_L,
		OP_TM1_R,
		OP_TM2,
		OP_MERGE,
		OP_PU_PUT,
		OP_PU_RD,
		OP_PU_CMP,
		OP_WK_ROOT,
		OP_WK_RN,
		OP_WK_EMIT,
		OP_WK_PUSH,
		OP_WK_POP,
		OP_WK_LD
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic cnt_ge2;
		logic hi_zero;
		logic len_gt1;
		logic sd_done;
		logic i_zero;
		logic pu_move;
		logic leaf;
		logic sp_zero;
		logic out_free;
	} stat_t;

endpackage

### sv/hcb_ctrl.sv
module hcb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last,
	output logic           in_ready,
	input  hcb_pkg::stat_t stat,
	output hcb_pkg::cmd_t  cmd
);

	typedef enum logic [19:0] {
		S_IDLE   = 20'h00001,
		S_HSTART = 20'h00002,
		S_HRD    = 20'h00004,
		S_HX     = 20'h00008,
		S_SD_RL  = 20'h00010,
		S_SD_RR  = 20'h00020,
		S_SD_CMP = 20'h00040,
		S_HNEXT  = 20'h00080,
		S_TM0    = 20'h00100,
		S_RDTOP  = 20'h00200,
		S_TM1    = 20'h00400,
		S_TM2    = 20'h00800,
		S_MRG    = 20'h01000,
		S_PU_CHK = 20'h02000,
		S_PU_CMP = 20'h04000,
		S_WK1    = 20'h08000,
		S_WK_RN  = 20'h10000,
		S_WK_EV  = 20'h20000,
		S_WK_POP = 20'h40000,
		S_WK_PL  = 20'h80000
	} state_t;

	typedef enum logic [1:0] {
		RET_HEAP,
		RET_L,
		RET_R
	} ret_t;

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd.op  = hcb_pkg::OP_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = hcb_pkg::OP_LOAD;
					if (last)
						state_d = S_HSTART;
				end
			end
			S_HSTART: begin
				cmd.op  = hcb_pkg::OP_HINIT;
				state_d = stat.cnt_ge2 ? S_HRD : S_TM0;
			end
			S_HRD: begin
				cmd.op  = hcb_pkg::OP_RD_HI;
				state_d = S_HX;
			end
			S_HX: begin
				cmd.op  = hcb_pkg::OP_LD_X;
				ret_d   = RET_HEAP;
				state_d = S_SD_RL;
			end
			S_SD_RL: begin
				cmd.op  = hcb_pkg::OP_SD_RL;
				state_d = S_SD_RR;
			end
			S_SD_RR: begin
				cmd.op  = hcb_pkg::OP_SD_RR;
				state_d = S_SD_CMP;
			end
			S_SD_CMP: begin
				cmd.op = hcb_pkg::OP_SD_CMP;
				if (!stat.sd_done)
					state_d = S_SD_RL;
				else begin
					case (ret_q)
						RET_HEAP: state_d = S_HNEXT;
						RET_L:    state_d = S_RDTOP;
						RET_R:    state_d = S_MRG;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_HNEXT: begin
				cmd.op  = hcb_pkg::OP_HDEC;
				state_d = stat.hi_zero ? S_TM0 : S_HRD;
			end
			S_TM0: begin
				// heap[0] is either the first minimum or the tree root
				cmd.op = hcb_pkg::OP_RD_TOP;
				ret_d  = RET_L;
				state_d = stat.len_gt1 ? S_TM1 : S_WK1;
			end
			S_RDTOP: begin
				cmd.op  = hcb_pkg::OP_RD_TOP;
				ret_d   = RET_R;
				state_d = S_TM1;
			end
			S_TM1: begin
				cmd.op  = (ret_q == RET_L) ? hcb_pkg::OP_TM1_L : hcb_pkg::OP_TM1_R;
				state_d = S_TM2;
			end
			S_TM2: begin
				cmd.op  = hcb_pkg::OP_TM2;
				state_d = S_SD_RL;
			end
			S_MRG: begin
				cmd.op  = hcb_pkg::OP_MERGE;
				state_d = S_PU_CHK;
			end
			S_PU_CHK: begin
				if (stat.i_zero) begin
					cmd.op  = hcb_pkg::OP_PU_PUT;
					state_d = S_TM0;
				end else begin
					cmd.op  = hcb_pkg::OP_PU_RD;
					state_d = S_PU_CMP;
				end
			end
			S_PU_CMP: begin
				cmd.op  = hcb_pkg::OP_PU_CMP;
				state_d = stat.pu_move ? S_PU_CHK : S_TM0;
			end
			S_WK1: begin
				cmd.op  = hcb_pkg::OP_WK_ROOT;
				state_d = S_WK_RN;
			end
			S_WK_RN: begin
				cmd.op  = hcb_pkg::OP_WK_RN;
				state_d = S_WK_EV;
			end
			S_WK_EV: begin
				if (!stat.leaf) begin
					cmd.op  = hcb_pkg::OP_WK_PUSH;
					state_d = S_WK_RN;
				end else if (stat.out_free) begin
					cmd.op  = hcb_pkg::OP_WK_EMIT;
					state_d = stat.sp_zero ? S_IDLE : S_WK_POP;
				end
			end
			S_WK_POP: begin
				cmd.op  = hcb_pkg::OP_WK_POP;
				state_d = S_WK_PL;
			end
			S_WK_PL: begin
				cmd.op  = hcb_pkg::OP_WK_LD;
				state_d = S_WK_RN;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= RET_HEAP;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

endmodule

### sv/hcb_dp.sv
module hcb_dp #(
	parameter int MAX_SYMBOLS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hcb_pkg::cmd_t                    cmd,
	output hcb_pkg::stat_t                   stat,
	input  logic [hcb_pkg::SYM_W-1:0]        symbol,
	input  logic [hcb_pkg::FREQ_W-1:0]       frequency,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [hcb_pkg::SYM_W-1:0]        symbol_res,
	output logic [hcb_pkg::LEN_W-1:0]        code_length,
	output logic [hcb_pkg::CODE_W-1:0]       code_bits,
	output logic                             last_code,
	output logic                             overflowed
);

	localparam int NODES = 2 * MAX_SYMBOLS;
	localparam int NW    = $clog2(NODES);
	localparam int HW    = $clog2(MAX_SYMBOLS);
	localparam int CW    = $clog2(MAX_SYMBOLS + 1);
	localparam int PW    = HW + 2;
	localparam int WW    = hcb_pkg::WEIGHT_W;
	localparam int EW    = WW + NW;
	localparam int MW    = 2 * NW + hcb_pkg::SYM_W + 1;
	localparam int SW    = 2 * NW + hcb_pkg::CODE_W;

	// heap entries carry their weight next to the node index
	logic [EW-1:0] heap_mem [MAX_SYMBOLS];
	logic [MW-1:0] node_mem [NODES];
	logic [SW-1:0] stk_mem  [MAX_SYMBOLS];

	logic [EW-1:0] heap_rd_q;
	logic [MW-1:0] node_rd_q;
	logic [SW-1:0] stk_rd_q;

	logic                 heap_we, heap_re, node_we, node_re, stk_we, stk_re;
	logic [HW-1:0]        heap_wa, heap_ra, stk_wa, stk_ra;
	logic [NW-1:0]        node_wa, node_ra;
	logic [EW-1:0]        heap_wd;
	logic [MW-1:0]        node_wd;
	logic [SW-1:0]        stk_wd;

	logic [CW-1:0] cnt_q, len_q, sp_q;
	logic          ovf_q;
	logic [PW-1:0] i_q;
	logic [HW-1:0] hi_q;
	logic [NW-1:0] next_q;
	logic [EW-1:0] x_q, lv_q, l_q, r_q;
	logic [NW-1:0] cur_nd_q, cur_d_q;
	logic [hcb_pkg::CODE_W-1:0] cur_c_q;

	logic                       ov_q;
	logic [hcb_pkg::SYM_W-1:0]  sym_o_q;
	logic [hcb_pkg::LEN_W-1:0]  len_o_q;
	logic [hcb_pkg::CODE_W-1:0] code_o_q;
	logic                       lastc_q, ovfl_q;

	logic [PW-1:0] lc, rc, len_p, best, par;
	logic [EW-1:0] best_e;
	logic [WW-1:0] x_w, lv_w, rv_w, bw;
	logic          sd_done, pu_move, has_room;
	logic [CW-1:0] len_m1, sp_m1, cnt_m2;
	logic [NW-1:0] d_inc, node_left, node_right;
	logic [7:0]    d_ext;

	assign x_w   = x_q[EW-1:NW];
	assign lv_w  = lv_q[EW-1:NW];
	assign rv_w  = heap_rd_q[EW-1:NW];
	assign lc    = PW'({i_q, 1'b1});
	assign rc    = lc + PW'(1);
	assign len_p = PW'(len_q);
	assign par   = (i_q - PW'(1)) >> 1;
	assign len_m1 = len_q - CW'(1);
	assign sp_m1  = sp_q - CW'(1);
	assign cnt_m2 = (cnt_q - CW'(2)) >> 1;
	assign d_inc  = cur_d_q + NW'(1);
	assign d_ext  = 8'(cur_d_q);
	assign has_room   = (cnt_q < CW'(MAX_SYMBOLS));
	assign node_left  = node_rd_q[MW-1 -: NW];
	assign node_right = node_rd_q[MW-1-NW -: NW];
	assign pu_move    = (x_w < rv_w);

	// strict less-than, left child tried first
	always_comb begin
		best   = i_q;
		best_e = x_q;
		bw     = x_w;
		if (lc < len_p && lv_w < bw) begin
			best   = lc;
			best_e = lv_q;
			bw     = lv_w;
		end
		if (rc < len_p && rv_w < bw) begin
			best   = rc;
			best_e = heap_rd_q;
		end
	end
	assign sd_done = (best == i_q);

	assign stat.cnt_ge2  = (cnt_q >= CW'(2));
	assign stat.hi_zero  = (hi_q == '0);
	assign stat.len_gt1  = (len_q > CW'(1));
	assign stat.sd_done  = sd_done;
	assign stat.i_zero   = (i_q == '0);
	assign stat.pu_move  = pu_move;
	assign stat.leaf     = node_rd_q[0];
	assign stat.sp_zero  = (sp_q == '0);
	assign stat.out_free = !ov_q || out_ready;

	always_comb begin
		heap_we = 1'b0;
		heap_re = 1'b0;
		heap_wa = i_q[HW-1:0];
		heap_ra = '0;
		heap_wd = x_q;
		node_we = 1'b0;
		node_re = 1'b0;
		node_wa = next_q;
		node_ra = cur_nd_q;
		node_wd = {l_q[NW-1:0], r_q[NW-1:0], hcb_pkg::SYM_W'(0), 1'b0};
		stk_we  = 1'b0;
		stk_re  = 1'b0;
		stk_wa  = sp_q[HW-1:0];
		stk_ra  = sp_m1[HW-1:0];
		stk_wd  = {node_right, d_inc, cur_c_q[hcb_pkg::CODE_W-2:0], 1'b1};
		case (cmd.op)
			hcb_pkg::OP_LOAD: begin
				if (has_room) begin
					heap_we = 1'b1;
					heap_wa = cnt_q[HW-1:0];
					heap_wd = {WW'(frequency), NW'(cnt_q)};
					node_we = 1'b1;
					node_wa = NW'(cnt_q);
					node_wd = {NW'(0), NW'(0), symbol, 1'b1};
				end
			end
			hcb_pkg::OP_RD_HI: begin
				heap_re = 1'b1;
				heap_ra = hi_q;
			end
			hcb_pkg::OP_SD_RL: begin
				heap_re = 1'b1;
				heap_ra = lc[HW-1:0];
			end
			hcb_pkg::OP_SD_RR: begin
				heap_re = 1'b1;
				heap_ra = rc[HW-1:0];
			end
			hcb_pkg::OP_SD_CMP: begin
				heap_we = 1'b1;
				heap_wd = sd_done ? x_q : best_e;
			end
			hcb_pkg::OP_RD_TOP: heap_re = 1'b1;
			hcb_pkg::OP_TM1_L, hcb_pkg::OP_TM1_R: begin
				heap_re = 1'b1;
				heap_ra = len_m1[HW-1:0];
			end
			hcb_pkg::OP_MERGE: node_we = 1'b1;
			hcb_pkg::OP_PU_PUT: heap_we = 1'b1;
			hcb_pkg::OP_PU_RD: begin
				heap_re = 1'b1;
				heap_ra = par[HW-1:0];
			end
			hcb_pkg::OP_PU_CMP: begin
				heap_we = 1'b1;
				heap_wd = pu_move ? heap_rd_q : x_q;
			end
			hcb_pkg::OP_WK_RN:   node_re = 1'b1;
			hcb_pkg::OP_WK_PUSH: stk_we  = 1'b1;
			hcb_pkg::OP_WK_POP:  stk_re  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (heap_we)
			heap_mem[heap_wa] <= heap_wd;
		if (heap_re)
			heap_rd_q <= heap_mem[heap_ra];
		if (node_we)
			node_mem[node_wa] <= node_wd;
		if (node_re)
			node_rd_q <= node_mem[node_ra];
		if (stk_we)
			stk_mem[stk_wa] <= stk_wd;
		if (stk_re)
			stk_rd_q <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			if (cmd.op == hcb_pkg::OP_WK_EMIT)
				ov_q <= 1'b1;
			else if (ov_q && out_ready)
				ov_q <= 1'b0;
			case (cmd.op)
				hcb_pkg::OP_LOAD: begin
					if (has_room)
						cnt_q <= cnt_q + CW'(1);
					else
						ovf_q <= 1'b1;
				end
				hcb_pkg::OP_WK_EMIT: begin
					// final leaf: ready for a new symbol set
					if (sp_q == '0) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			hcb_pkg::OP_HINIT: begin
				len_q  <= cnt_q;
				next_q <= NW'(cnt_q);
				hi_q   <= cnt_m2[HW-1:0];
			end
			hcb_pkg::OP_LD_X: begin
				x_q <= heap_rd_q;
				i_q <= PW'(hi_q);
			end
			hcb_pkg::OP_SD_RR: lv_q <= heap_rd_q;
			hcb_pkg::OP_SD_CMP: begin
				if (!sd_done)
					i_q <= best;
			end
			hcb_pkg::OP_HDEC: begin
				if (hi_q != '0)
					hi_q <= hi_q - HW'(1);
			end
			hcb_pkg::OP_TM1_L: l_q <= heap_rd_q;
			hcb_pkg::OP_TM1_R: r_q <= heap_rd_q;
			hcb_pkg::OP_TM2: begin
				x_q   <= heap_rd_q;
				len_q <= len_m1;
				i_q   <= '0;
			end
			hcb_pkg::OP_MERGE: begin
				x_q    <= {l_q[EW-1:NW] + r_q[EW-1:NW], next_q};
				i_q    <= len_p;
				len_q  <= len_q + CW'(1);
				next_q <= next_q + NW'(1);
			end
			hcb_pkg::OP_PU_CMP: begin
				if (pu_move)
					i_q <= par;
			end
			hcb_pkg::OP_WK_ROOT: begin
				cur_nd_q <= heap_rd_q[NW-1:0];
				cur_d_q  <= '0;
				cur_c_q  <= '0;
				sp_q     <= '0;
			end
			hcb_pkg::OP_WK_PUSH: begin
				cur_nd_q <= node_left;
				cur_d_q  <= d_inc;
				cur_c_q  <= {cur_c_q[hcb_pkg::CODE_W-2:0], 1'b0};
				sp_q     <= sp_q + CW'(1);
			end
			hcb_pkg::OP_WK_POP: sp_q <= sp_m1;
			hcb_pkg::OP_WK_LD: begin
				cur_nd_q <= stk_rd_q[SW-1 -: NW];
				cur_d_q  <= stk_rd_q[SW-1-NW -: NW];
				cur_c_q  <= stk_rd_q[hcb_pkg::CODE_W-1:0];
			end
			hcb_pkg::OP_WK_EMIT: begin
				sym_o_q  <= node_rd_q[hcb_pkg::SYM_W:1];
				len_o_q  <= (d_ext > 8'd31) ? 5'd31 : d_ext[hcb_pkg::LEN_W-1:0];
				code_o_q <= cur_c_q;
				lastc_q  <= (sp_q == '0);
				ovfl_q   <= ovf_q;
			end
			default: ;
		endcase
	end

	assign out_valid   = ov_q;
	assign symbol_res  = sym_o_q;
	assign code_length = len_o_q;
	assign code_bits   = code_o_q;
	assign last_code   = lastc_q;
	assign overflowed  = ovfl_q;

endmodule

### sv/huffman_code_builder.sv
// Huffman code builder. Symbols load one per request, up to MAX_SYMBOLS; further symbols
// are dropped and reported on overflowed. The request marked last starts the build, and
// in_ready stays low until the last code has been handed to the output register. The build
// runs on one single-port heap memory with registered reads: a heapify by sift-down, then
// per merge two extracts, each a sift-down, and an insert of the merged node by sift-up.
// The tree walk then visits every node and waits while the output is stalled. One code
// comes out per leaf in left-first preorder, the first branch in the top valid code bit.
module huffman_code_builder #(
	parameter int MAX_SYMBOLS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [hcb_pkg::SYM_W-1:0]        symbol,
	input  logic [hcb_pkg::FREQ_W-1:0]       frequency,
	input  logic                             last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [hcb_pkg::SYM_W-1:0]        symbol_res,
	output logic [hcb_pkg::LEN_W-1:0]        code_length,
	output logic [hcb_pkg::CODE_W-1:0]       code_bits,
	output logic                             last_code,
	output logic                             overflowed
);

	hcb_pkg::cmd_t  cmd;
	hcb_pkg::stat_t stat;

	hcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hcb_dp #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.symbol      (symbol),
		.frequency   (frequency),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.symbol_res  (symbol_res),
		.code_length (code_length),
		.code_bits   (code_bits),
		.last_code   (last_code),
		.overflowed  (overflowed)
	);

endmodule

### sv/hcb_checker.sv
`include "huffman_code_builder_assert.svh"

module hcb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [hcb_pkg::SYM_W-1:0]        symbol,
	input logic [hcb_pkg::FREQ_W-1:0]       frequency,
	input logic                             last,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [hcb_pkg::SYM_W-1:0]        symbol_res,
	input logic [hcb_pkg::LEN_W-1:0]        code_length,
	input logic [hcb_pkg::CODE_W-1:0]       code_bits,
	input logic                             last_code,
	input logic                             overflowed
);

	// a held result keeps its payload
	`HCB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(symbol_res) && $stable(code_bits) && $stable(last_code), "result dropped or changed while stalled")

	// the last request starts a build, so no request is taken right after
	`HCB_ASSERT(a_build_starts, in_valid && in_ready && last |=> !in_ready, "request taken while building")

	// a code with a length below 31 has no bits above its length
	`HCB_ASSERT(a_code_fits, out_valid && code_length != 5'd31 |-> (code_bits >> code_length) == 31'd0, "code bits beyond code length")

	`HCB_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result shown during reset")

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (.*);

### tb/sv/huffman_code_builder_test.sv
`timescale 1ns / 100ps

class code_scoreboard;
	typedef struct {
		logic [7:0]  sym;
		logic [4:0]  len;
		logic [30:0] bits;
		logic        fin;
		logic        ovf;
	} code_t;

	int          max_syms;
	logic [7:0]  leaf_sym[64];
	int unsigned weight[64];
	int          left_of[64];
	int          right_of[64];
	bit          is_leaf[64];
	int          heap[64];
	int          heap_len;
	int          loaded;
	bit          dropped;
	code_t       pending[$];
	int          mismatches;

	function new(int n);
		max_syms = n;
		loaded = 0;
		dropped = 0;
		mismatches = 0;
	endfunction

	function void sift_down(int i);
		int best, lc, rc, t;
		forever begin
			best = i;
			lc = 2 * i + 1;
			rc = 2 * i + 2;
			if (lc < heap_len && weight[heap[lc]] < weight[heap[best]])
				best = lc;
			if (rc < heap_len && weight[heap[rc]] < weight[heap[best]])
				best = rc;
			if (best == i)
				return;
			t = heap[best];
			heap[best] = heap[i];
			heap[i] = t;
			i = best;
		end
	endfunction

	function int take_min();
		int top;
		top = heap[0];
		heap[0] = heap[heap_len - 1];
		heap_len--;
		sift_down(0);
		return top;
	endfunction

	function void insert(int nd);
		int i, p;
		i = heap_len;
		heap_len++;
		while (i != 0) begin
			p = (i - 1) / 2;
			if (!(weight[nd] < weight[heap[p]]))
				break;
			heap[i] = heap[p];
			i = p;
		end
		heap[i] = nd;
	endfunction

	// store a symbol; on the final one build the tree and queue the codes
	function void note_request(logic [7:0] sym, logic [15:0] freq, logic fin);
		int nxt, sp, l, r, nd;
		int stk[64];
		int dep[64];
		logic [30:0] cod[64];
		code_t c;
		if (loaded < max_syms) begin
			leaf_sym[loaded] = sym;
			weight[loaded] = freq;
			is_leaf[loaded] = 1;
			loaded++;
		end else
			dropped = 1;
		if (!fin)
			return;
		for (int i = 0; i < loaded; i++)
			heap[i] = i;
		heap_len = loaded;
		if (loaded >= 2)
			for (int i = (loaded - 2) / 2; i >= 0; i--)
				sift_down(i);
		nxt = loaded;
		while (heap_len > 1) begin
			l = take_min();
			r = take_min();
			weight[nxt] = (weight[l] + weight[r]) & 22'h3fffff;
			left_of[nxt] = l;
			right_of[nxt] = r;
			is_leaf[nxt] = 0;
			insert(nxt);
			nxt++;
		end
		stk[0] = heap[0];
		dep[0] = 0;
		cod[0] = '0;
		sp = 1;
		while (sp > 0) begin
			sp--;
			nd = stk[sp];
			if (is_leaf[nd]) begin
				c.sym = leaf_sym[nd];
				c.len = (dep[sp] > 31) ? 5'd31 : 5'(dep[sp]);
				c.bits = cod[sp];
				c.fin = (sp == 0);
				c.ovf = dropped;
				pending.push_back(c);
			end else begin
				dep[sp + 1] = dep[sp] + 1;
				cod[sp + 1] = {cod[sp][29:0], 1'b0};
				stk[sp + 1] = left_of[nd];
				cod[sp] = {cod[sp][29:0], 1'b1};
				dep[sp] = dep[sp] + 1;
				stk[sp] = right_of[nd];
				sp += 2;
			end
		end
		loaded = 0;
		dropped = 0;
	endfunction

	function void check_result(logic [7:0] sym, logic [4:0] len, logic [30:0] bits,
			logic fin, logic ovf);
		code_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected code: sym=%0h len=%0d bits=%0h", sym, len, bits);
			return;
		end
		e = pending.pop_front();
		if (sym !== e.sym || len !== e.len || bits !== e.bits || fin !== e.fin
				|| ovf !== e.ovf) begin
			mismatches++;
			if (mismatches <= 10)
				$display("code mismatch: exp sym=%0h len=%0d bits=%0h last=%0b ovf=%0b, got sym=%0h len=%0d bits=%0h last=%0b ovf=%0b",
					e.sym, e.len, e.bits, e.fin, e.ovf, sym, len, bits, fin, ovf);
		end
	endfunction
endclass

module huffman_code_builder_test;

	localparam int MAX_SYMBOLS = 32;
	localparam int STALL_LIMIT = 20000;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [hcb_pkg::SYM_W-1:0]    symbol;
	logic [hcb_pkg::FREQ_W-1:0]   frequency;
	logic                         last;
	logic                         out_valid;
	logic                         out_ready;
	logic [hcb_pkg::SYM_W-1:0]    symbol_res;
	logic [hcb_pkg::LEN_W-1:0]    code_length;
	logic [hcb_pkg::CODE_W-1:0]   code_bits;
	logic                         last_code;
	logic                         overflowed;

	code_scoreboard sb;
	int unsigned cycle_no;
	int          requests_taken;
	int          idle_cycles;

	huffman_code_builder #(.MAX_SYMBOLS(MAX_SYMBOLS)) uut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// stretch with no idling on either side
	function automatic bit may_idle();
		return !(cycle_no >= 2000 && cycle_no < 5000) && ($urandom_range(99) < 32);
	endfunction

	task automatic send_request(logic [7:0] s, logic [15:0] f, logic fin);
		while (may_idle()) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		symbol <= s;
		frequency <= f;
		last <= fin;
		do @(posedge clk); while (!in_ready);
		sb.note_request(s, f, fin);
		requests_taken++;
	endtask

	task automatic send_set(int n, bit narrow);
		logic [15:0] f;
		for (int i = 0; i < n; i++) begin
			f = narrow ? 16'($urandom_range(7)) : 16'($urandom);
			send_request(8'($urandom), f, i == n - 1);
		end
	endtask

	// sender
	initial begin
		int n;
		sb = new(MAX_SYMBOLS);
		requests_taken = 0;
		arst_n = 0;
		in_valid = 0;
		symbol = '0;
		frequency = '0;
		last = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// single symbol
		send_request(8'h00, 16'hffff, 1);
		// zero weights at both symbol extremes
		send_request(8'hff, 16'h0000, 0);
		send_request(8'h00, 16'h0000, 1);
		// equal weights
		for (int i = 0; i < 4; i++)
			send_request(8'(i + 8'h40), 16'd5, i == 3);
		// extreme weights mixed
		send_request(8'haa, 16'hffff, 0);
		send_request(8'h55, 16'h0001, 0);
		send_request(8'h0f, 16'hffff, 0);
		send_request(8'hf0, 16'h0000, 0);
		send_request(8'h81, 16'h8000, 1);
		while (requests_taken < 200) begin
			if ($urandom_range(7) == 0)
				n = $urandom_range(MAX_SYMBOLS + 4, MAX_SYMBOLS - 1);
			else
				n = $urandom_range(10, 1);
			send_set(n, $urandom_range(1));
		end
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// receiver with one long hold-off once 60 requests have been taken
	initial begin
		int hold;
		out_ready = 0;
		hold = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (requests_taken >= 60 && hold == 0)
				hold = 600;
			if (hold > 1) begin
				out_ready <= 0;
				hold--;
			end else
				out_ready <= !may_idle();
		end
	end

	// result check and watchdog
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(symbol_res, code_length, code_bits, last_code, overflowed);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				idle_cycles <= 0;
			else if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		cycle_no = 0;
		idle_cycles = 0;
	end
endmodule
